>>> rtl/core/bool_expr_infix_to_postfix_core_macros.svh
// Assertion helpers shared by the core's RTL files.
// Both sample on clk and are disabled while rst_n is low.
`ifndef BOOL_EXPR_INFIX_TO_POSTFIX_CORE_MACROS_SVH
`define BOOL_EXPR_INFIX_TO_POSTFIX_CORE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define BEXI2P_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// Antecedent implies consequent in the same cycle.
`define BEXI2P_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

>>> rtl/core/bexi2p_pkg.sv
`default_nettype none

package bexi2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_AND   = 8'h2A;
  localparam logic [7:0] CH_OR    = 8'h2B;
  localparam logic [7:0] CH_NOT   = 8'h2D;

  typedef enum logic [1:0] {
    OP_OPEN = 2'd0,
    OP_AND  = 2'd1,
    OP_OR   = 2'd2,
    OP_NOT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_BAD_CHAR   = 3'd1,
    STS_OVERFLOW   = 3'd2,
    STS_UNMATCHED  = 3'd3,
    STS_UNBALANCED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_OPERAND = 2'd1,
    KIND_CLOSE   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CL_OPERAND,
    CL_OPEN,
    CL_OPER,
    CL_CLOSE,
    CL_BAD
  } cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHUNT,
    S_MAIN,
    S_CLOSE,
    S_FLUSH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       expr_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       has_sym;
    logic [2:0] status;
    logic       run_last;
  } out_req_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    op_t  code;
  } stk_cmd_t;

  typedef struct packed {
    op_t  top;
    logic above;
    logic full;
  } stk_stat_t;

  function automatic logic [7:0] op_char(input op_t op);
    logic [7:0] c;
    unique case (op)
      OP_AND:  c = CH_AND;
      OP_OR:   c = CH_OR;
      OP_NOT:  c = CH_NOT;
      default: c = CH_OPEN;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] op_prec(input op_t op);
    logic [1:0] p;
    unique case (op)
      OP_AND, OP_NOT: p = 2'd3;
      OP_OR:          p = 2'd2;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic cls_t ch_class(input logic [7:0] c);
    cls_t k;
    if (is_letter(c) || is_digit(c)) begin
      k = CL_OPERAND;
    end else if (c == CH_OPEN) begin
      k = CL_OPEN;
    end else if (c == CH_CLOSE) begin
      k = CL_CLOSE;
    end else if (c == CH_AND || c == CH_OR || c == CH_NOT) begin
      k = CL_OPER;
    end else begin
      k = CL_BAD;
    end
    return k;
  endfunction

  function automatic op_t ch_op(input logic [7:0] c);
    op_t o;
    if (c == CH_AND) begin
      o = OP_AND;
    end else if (c == CH_OR) begin
      o = OP_OR;
    end else begin
      o = OP_NOT;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bool_expr_infix_to_postfix_core.sv
// Channel  Direction  Payload (bexi2p_pkg)       Handshake
// in_      input      in_req_t  {ch, expr_end}   in_valid / in_stall
// out_     output     out_req_t {sym, has_sym,   out_valid / out_stall
//                                status, run_last}
//
// Sequence: each character passes S_IDLE (accept), S_MAIN (dispatch) and S_DONE
//   (close-out), with extra steps for each operator popped, for an operator or
//   implicit AND push, for the last step of a ')' and for the end flush.
// Reset: rst_n is synchronous, active low; empty the stack, clear prev class.
// Stalls: out_stall holds the sequencer only when a result must move into the
//   output register; in_stall is high while a character is being worked on.
`default_nettype none
`include "bool_expr_infix_to_postfix_core_macros.svh"

module bool_expr_infix_to_postfix_core (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire bexi2p_pkg::in_req_t  in_req,
  output logic                      out_valid,
  input  wire                       out_stall,
  output bexi2p_pkg::out_req_t      out_req
);
  import bexi2p_pkg::*;

  state_t     state_r, state_nxt;
  kind_t      prev_r, prev_nxt;
  op_t        op_r, op_nxt;
  logic       and_phase_r, and_phase_nxt;
  logic [7:0] ch_r;
  logic       last_r;
  cls_t       cls_r;

  // One-deep hold for the newest result: it is released only once we know
  // whether another result follows, which settles run_last.
  logic       pend_v_r;
  out_req_t   pend_r;
  logic       out_valid_r;
  out_req_t   out_req_r;

  logic       in_fire;
  logic       need_and;
  logic       gen;
  out_req_t   gen_res;
  out_req_t   move_res;
  logic       move;
  logic       out_free;
  logic       adv;
  logic       pop_any;
  logic       pop_shunt;
  stk_cmd_t   stk_cmd;
  stk_cmd_t   stk_cmd_q;
  stk_stat_t  stk;
  state_t     after_seq;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  // Implicit AND before a letter or '(' that follows an operand or ')'.
  assign need_and = (is_letter(in_req.ch) || in_req.ch == CH_OPEN) &&
                    (prev_r == KIND_OPERAND || prev_r == KIND_CLOSE);

  assign pop_any   = stk.above && stk.top != OP_OPEN;
  assign pop_shunt = pop_any && (op_prec(stk.top) >= op_prec(op_r));
  assign after_seq = last_r ? S_FLUSH : S_DONE;

  // A result leaves the hold register when a newer one arrives or at close-out.
  assign out_free = !out_valid_r || !out_stall;
  assign move     = pend_v_r && (gen || state_r == S_DONE);
  assign adv      = !move || out_free;

  // Mark the result that closes out the request.
  always_comb begin
    move_res          = pend_r;
    move_res.run_last = (state_r == S_DONE);
  end

  bexi2p_stack u_stack (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (stk_cmd_q),
    .stat (stk)
  );

  // Stack commands take effect only when the sequencer advances.
  always_comb begin
    stk_cmd_q = stk_cmd;
    if (!adv) begin
      stk_cmd_q = '0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = need_and ? S_SHUNT : S_MAIN;
        end
      end
      S_SHUNT: begin
        if (!pop_shunt) begin
          state_nxt = and_phase_r ? S_MAIN : after_seq;
        end
      end
      S_MAIN: begin
        unique case (cls_r)
          CL_OPER:  state_nxt = S_SHUNT;
          CL_CLOSE: state_nxt = S_CLOSE;
          default:  state_nxt = after_seq;
        endcase
      end
      S_CLOSE: begin
        if (!pop_any) begin
          state_nxt = after_seq;
        end
      end
      S_FLUSH: begin
        if (!pop_any) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: result generation, stack commands, side state.
  always_comb begin
    gen           = 1'b0;
    gen_res       = '0;
    stk_cmd       = '0;
    prev_nxt      = prev_r;
    op_nxt        = op_r;
    and_phase_nxt = and_phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = OP_AND;
          and_phase_nxt = need_and;
        end
      end
      S_SHUNT: begin
        if (pop_shunt) begin
          gen             = 1'b1;
          gen_res.sym     = op_char(stk.top);
          gen_res.has_sym = 1'b1;
          stk_cmd.pop     = 1'b1;
        end else begin
          stk_cmd.push = 1'b1;
          stk_cmd.code = op_r;
          if (stk.full) begin
            gen            = 1'b1;
            gen_res.status = STS_OVERFLOW;
          end
        end
      end
      S_MAIN: begin
        unique case (cls_r)
          CL_OPERAND: begin
            gen             = 1'b1;
            gen_res.sym     = ch_r;
            gen_res.has_sym = 1'b1;
            prev_nxt        = KIND_OPERAND;
          end
          CL_OPEN: begin
            stk_cmd.push = 1'b1;
            stk_cmd.code = OP_OPEN;
            prev_nxt     = KIND_START;
            if (stk.full) begin
              gen            = 1'b1;
              gen_res.status = STS_OVERFLOW;
            end
          end
          CL_OPER: begin
            op_nxt        = ch_op(ch_r);
            and_phase_nxt = 1'b0;
            prev_nxt      = KIND_START;
          end
          CL_CLOSE: begin
            prev_nxt = KIND_CLOSE;
          end
          default: begin
            gen            = 1'b1;
            gen_res.status = STS_BAD_CHAR;
          end
        endcase
      end
      S_CLOSE: begin
        if (pop_any) begin
          gen             = 1'b1;
          gen_res.sym     = op_char(stk.top);
          gen_res.has_sym = 1'b1;
          stk_cmd.pop     = 1'b1;
        end else if (stk.above) begin
          // Drop the matching '('.
          stk_cmd.pop = 1'b1;
        end else begin
          gen            = 1'b1;
          gen_res.status = STS_UNMATCHED;
        end
      end
      S_FLUSH: begin
        if (pop_any) begin
          gen             = 1'b1;
          gen_res.sym     = op_char(stk.top);
          gen_res.has_sym = 1'b1;
          stk_cmd.pop     = 1'b1;
        end else begin
          if (stk.above) begin
            gen            = 1'b1;
            gen_res.status = STS_UNBALANCED;
          end
          stk_cmd.clear = 1'b1;
          prev_nxt      = KIND_START;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= KIND_START;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        state_r <= state_nxt;
        prev_r  <= prev_nxt;
        if (gen) begin
          pend_v_r <= 1'b1;
        end else if (state_r == S_DONE) begin
          pend_v_r <= 1'b0;
        end
      end
      if (move && adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r   <= in_req.ch;
      last_r <= in_req.expr_end;
      cls_r  <= ch_class(in_req.ch);
    end
    if (adv) begin
      op_r        <= op_nxt;
      and_phase_r <= and_phase_nxt;
      if (gen) begin
        pend_r <= gen_res;
      end
    end
    if (move && adv) begin
      out_req_r <= move_res;
    end
  end

  `BEXI2P_ASSERT_IMPLY(a_idle_nothing_held, state_r == S_IDLE, !pend_v_r)
  `BEXI2P_ASSERT_IMPLY(a_sym_means_ok, out_valid_r && out_req_r.has_sym,
                       out_req_r.status == STS_OK)
  `BEXI2P_ASSERT_IMPLY(a_accept_after_last, in_fire && out_valid_r, out_req_r.run_last)

endmodule

`default_nettype wire

>>> rtl/core/bexi2p_stack.sv
`default_nettype none
`include "bool_expr_infix_to_postfix_core_macros.svh"

module bexi2p_stack (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire bexi2p_pkg::stk_cmd_t  cmd,
  output bexi2p_pkg::stk_stat_t      stat
);
  import bexi2p_pkg::*;

  // Entry 0 is the '(' sentinel; it is never read, so it is never stored.
  op_t              mem [STACK_DEPTH];
  logic [LVL_W-1:0] level_r;
  logic [LVL_W-1:0] level_nxt;
  op_t              top_r;
  logic             full;
  logic [IDX_W-1:0] below_idx;

  assign full      = (level_r == LVL_W'(STACK_DEPTH));
  assign below_idx = IDX_W'(level_r - LVL_W'(2));

  always_comb begin
    stat.top   = top_r;
    stat.above = (level_r > LVL_W'(1));
    stat.full  = full;
  end

  always_comb begin
    level_nxt = level_r;
    if (cmd.clear) begin
      level_nxt = LVL_W'(1);
    end else if (cmd.pop) begin
      level_nxt = level_r - LVL_W'(1);
    end else if (cmd.push && !full) begin
      level_nxt = level_r + LVL_W'(1);
    end
  end

  // Hold the top entry in a register; reload it from the entry below on a pop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LVL_W'(1);
      top_r   <= OP_OPEN;
    end else begin
      level_r <= level_nxt;
      if (cmd.clear) begin
        top_r <= OP_OPEN;
      end else if (cmd.pop) begin
        top_r <= (level_r == LVL_W'(2)) ? OP_OPEN : mem[below_idx];
      end else if (cmd.push && !full) begin
        top_r <= cmd.code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.pop && !cmd.clear && !full) begin
      mem[level_r[IDX_W-1:0]] <= cmd.code;
    end
  end

  `BEXI2P_ASSERT_ALWAYS(a_level_nonzero, level_r != '0)
  `BEXI2P_ASSERT_ALWAYS(a_level_bound, level_r <= LVL_W'(STACK_DEPTH))
  `BEXI2P_ASSERT_IMPLY(a_pop_above_sentinel, cmd.pop, level_r > LVL_W'(1))

endmodule

`default_nettype wire

>>> test/bexi2p_postfix_checker.sv
`timescale 1ns / 100ps

module bexi2p_postfix_checker (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_stall,
  input  bexi2p_pkg::in_req_t  in_req,
  input  wire                  out_valid,
  input  wire                  out_stall,
  input  bexi2p_pkg::out_req_t out_req,
  output int                   mismatch_cnt,
  output int                   outstanding
);
  import bexi2p_pkg::*;

  localparam int MAX_RESULTS = 36;

  op_t         op_stk [STACK_DEPTH];
  int unsigned lvl;
  kind_t       prev_cls;
  out_req_t    step_res [$];
  out_req_t    postfix_q [$];
  int          err_cnt = 0;

  assign mismatch_cnt = err_cnt;

  function automatic logic [7:0] glyph(input op_t c);
    case (c)
      OP_AND:  return CH_AND;
      OP_OR:   return CH_OR;
      OP_NOT:  return CH_NOT;
      default: return CH_OPEN;
    endcase
  endfunction

  function automatic int rank(input op_t c);
    if (c == OP_AND || c == OP_NOT) return 3;
    if (c == OP_OR) return 2;
    return 0;
  endfunction

  function automatic op_t top_op();
    return op_stk[(lvl - 1) % STACK_DEPTH];
  endfunction

  // Drop anything past the per-request result cap.
  function automatic void emit(input logic [7:0] s, input logic h, input status_t st);
    out_req_t r;
    if (step_res.size() >= MAX_RESULTS) return;
    r.sym      = s;
    r.has_sym  = h;
    r.status   = st;
    r.run_last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void push_op(input op_t c);
    if (lvl < STACK_DEPTH) begin
      op_stk[lvl] = c;
      lvl++;
    end else begin
      emit(8'h00, 1'b0, STS_OVERFLOW);
    end
  endfunction

  function automatic void shunt(input op_t c);
    while (lvl > 1 && top_op() != OP_OPEN && rank(top_op()) >= rank(c)) begin
      emit(glyph(top_op()), 1'b1, STS_OK);
      lvl--;
    end
    push_op(c);
  endfunction

  // Pop down to the topmost '('; true if that '(' is not the sentinel.
  function automatic bit unwind_to_open();
    while (lvl > 1 && top_op() != OP_OPEN) begin
      emit(glyph(top_op()), 1'b1, STS_OK);
      lvl--;
    end
    return lvl > 1;
  endfunction

  function automatic void clear_stack();
    op_stk[0] = OP_OPEN;
    lvl       = 1;
    prev_cls  = KIND_START;
  endfunction

  function automatic void convert_char(input in_req_t r);
    logic is_alpha;
    logic is_num;
    logic after_val;
    op_t  oc;
    is_alpha  = (r.ch >= "a" && r.ch <= "z") || (r.ch >= "A" && r.ch <= "Z");
    is_num    = r.ch >= "0" && r.ch <= "9";
    after_val = prev_cls == KIND_OPERAND || prev_cls == KIND_CLOSE;
    step_res.delete();

    if ((is_alpha || r.ch == CH_OPEN) && after_val) shunt(OP_AND);

    if (is_alpha || is_num) begin
      emit(r.ch, 1'b1, STS_OK);
      prev_cls = KIND_OPERAND;
    end else if (r.ch == CH_OPEN) begin
      push_op(OP_OPEN);
      prev_cls = KIND_START;
    end else if (r.ch == CH_AND || r.ch == CH_OR || r.ch == CH_NOT) begin
      oc = (r.ch == CH_AND) ? OP_AND : ((r.ch == CH_OR) ? OP_OR : OP_NOT);
      shunt(oc);
      prev_cls = KIND_START;
    end else if (r.ch == CH_CLOSE) begin
      if (unwind_to_open()) lvl--;
      else emit(8'h00, 1'b0, STS_UNMATCHED);
      prev_cls = KIND_CLOSE;
    end else begin
      emit(8'h00, 1'b0, STS_BAD_CHAR);
    end

    if (r.expr_end) begin
      if (unwind_to_open()) emit(8'h00, 1'b0, STS_UNBALANCED);
      clear_stack();
    end

    if (step_res.size() > 0) step_res[step_res.size() - 1].run_last = 1'b1;
    foreach (step_res[i]) postfix_q.push_back(step_res[i]);
  endfunction

  function automatic void flag_error(input string what);
    err_cnt++;
    if (err_cnt <= 10) $display("[%0t] postfix check: %s", $time, what);
  endfunction

  // Take the request before the result so a same-edge result still finds it.
  always @(posedge clk) begin
    out_req_t want;
    if (!rst_n) begin
      clear_stack();
      postfix_q.delete();
    end else begin
      if (in_valid && !in_stall) convert_char(in_req);
      if (out_valid && !out_stall) begin
        if (postfix_q.size() == 0) begin
          flag_error($sformatf("unexpected result sym=%h has_sym=%b status=%0d run_last=%b",
                               out_req.sym, out_req.has_sym, out_req.status,
                               out_req.run_last));
        end else begin
          want = postfix_q.pop_front();
          if (out_req.sym !== want.sym || out_req.has_sym !== want.has_sym ||
              out_req.status !== want.status || out_req.run_last !== want.run_last) begin
            flag_error($sformatf({"expected sym=%h has_sym=%b status=%0d run_last=%b,",
                                  " got sym=%h has_sym=%b status=%0d run_last=%b"},
                                 want.sym, want.has_sym, want.status, want.run_last,
                                 out_req.sym, out_req.has_sym, out_req.status,
                                 out_req.run_last));
          end
        end
      end
    end
    outstanding <= postfix_q.size();
  end

endmodule

>>> test/tb_bool_expr_infix_to_postfix_core.sv
`timescale 1ns / 100ps

module tb_bool_expr_infix_to_postfix_core;
  import bexi2p_pkg::*;

  localparam int RANDOM_ITEMS  = 450;
  localparam int MAX_GAP       = 18;
  localparam int LONG_HOLD     = 300;
  // Quiet cycles after the drain, long enough for any stray result to show.
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 2000000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  int         mismatches;
  int         outstanding;
  int         cycle_cnt = 0;
  int         gap_max   = MAX_GAP;
  bit         long_hold = 1'b0;
  int         sent_cnt  = 0;
  logic [7:0] expr_q [$];

  bool_expr_infix_to_postfix_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  // Watch both channels, predict the postfix stream and count mismatches.
  bexi2p_postfix_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req       (in_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_req      (out_req),
    .mismatch_cnt (mismatches),
    .outstanding  (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: abort a run that hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Pick a letter most of the time, sometimes a digit; covers both cases.
  function automatic logic [7:0] operand_char();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return 8'("0" + $urandom_range(0, 9));
    if (pick < 6) return 8'("a" + $urandom_range(0, 25));
    return 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] operator_char();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) return CH_AND;
    if (pick == 1) return CH_OR;
    return CH_NOT;
  endfunction

  // Build a mostly well-formed expression with random content: operands,
  // operators, NOT prefixes, nesting and juxtaposition (implicit AND).
  // About three in eight get broken by a dropped char, a stray byte or an
  // extra ')'.
  function automatic void build_expr();
    int         depth;
    int         target;
    int         pick;
    int         pos;
    bit         need_opnd;
    logic [7:0] stray;
    expr_q.delete();
    depth     = 0;
    need_opnd = 1'b1;
    target    = $urandom_range(1, 14);
    for (int step = 0; step < 40; step++) begin
      if (need_opnd) begin
        pick = $urandom_range(0, 9);
        if (pick < 6 || (pick < 9 && depth >= 6)) begin
          expr_q.push_back(operand_char());
          need_opnd = 1'b0;
        end else if (pick < 9) begin
          expr_q.push_back(CH_OPEN);
          depth++;
        end else begin
          expr_q.push_back(CH_NOT);
        end
      end else if (expr_q.size() >= target) begin
        break;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 3 && depth > 0) begin
          expr_q.push_back(CH_CLOSE);
          depth--;
        end else if (pick < 8) begin
          expr_q.push_back(operator_char());
          need_opnd = 1'b1;
        end else if (pick == 8) begin
          expr_q.push_back(operand_char());
        end else begin
          expr_q.push_back(CH_OPEN);
          depth++;
          need_opnd = 1'b1;
        end
      end
    end
    if (need_opnd) expr_q.push_back(operand_char());
    repeat (depth) expr_q.push_back(CH_CLOSE);

    pick  = $urandom_range(0, 7);
    pos   = $urandom_range(0, expr_q.size() - 1);
    stray = 8'($urandom_range(0, 255));
    if (pick == 0 && expr_q.size() > 1) expr_q.delete(pos);
    else if (pick == 1) expr_q.insert(pos, stray);
    else if (pick == 2) expr_q.insert(pos, CH_CLOSE);
  endfunction

  // Deep nesting: enough '(' and operators to run the stack near or past full,
  // then a random number of closes, so it may end balanced or not.
  function automatic void build_deep_expr();
    int levels;
    expr_q.delete();
    levels = $urandom_range(26, 40);
    repeat (levels) begin
      if ($urandom_range(0, 1) == 1) begin
        expr_q.push_back(operand_char());
        expr_q.push_back(operator_char());
      end
      expr_q.push_back(CH_OPEN);
    end
    expr_q.push_back(operand_char());
    repeat ($urandom_range(0, levels + 2)) expr_q.push_back(CH_CLOSE);
  endfunction

  // Offer one request after a random idle gap; hold it until accepted.
  // Keep valid high across back-to-back requests.
  task automatic offer(input logic [7:0] c, input logic last);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req   <= in_req_t'{ch: c, expr_end: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
  endtask

  task automatic send_expr();
    foreach (expr_q[i]) offer(expr_q[i], i == expr_q.size() - 1);
  endtask

  // Stop offering and wait for every predicted result to drain.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Result side: stall a random number of cycles before each result, with
  // calm stretches of no stalling, and one long hold-off on request.
  initial begin
    int  n;
    int  served;
    bit  calm;
    served = 0;
    calm   = 1'b0;
    forever begin
      if (served % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      n = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (long_hold) begin
        long_hold = 1'b0;
        n         = LONG_HOLD;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      served++;
    end
  end

  // Request side and verdict.
  initial begin
    int  rand_start;
    int  pick;
    bit  hold_done;
    bit  pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    offer(8'h00, 1'b0);     // all-zero byte: invalid character
    offer("a", 1'b0);       // lowest lowercase letter
    offer(CH_OPEN, 1'b0);   // '(' after an operand: implicit AND, then push
    offer("Z", 1'b0);       // highest uppercase letter
    offer(CH_OR, 1'b0);
    offer("9", 1'b0);
    offer("0", 1'b0);       // digit after an operand: no implicit AND
    offer(CH_CLOSE, 1'b0);  // pop '+', match the '('
    offer("z", 1'b0);       // letter after ')': implicit AND pops the older '*'
    offer(CH_NOT, 1'b0);
    offer("A", 1'b0);
    offer(CH_CLOSE, 1'b0);  // pops down to the sentinel: unmatched close
    offer(CH_OPEN, 1'b0);   // '(' after ')': implicit AND
    offer("b", 1'b0);
    offer(CH_AND, 1'b0);
    offer(8'hFF, 1'b1);     // all-ones byte on the last char: flush, unbalanced
    offer("q", 1'b1);       // one-character expression
    offer(CH_CLOSE, 1'b1);  // lone ')' as the whole expression
    offer(CH_OPEN, 1'b1);   // lone '(' as the whole expression
    offer("m", 1'b0);
    offer(CH_AND, 1'b0);
    offer("n", 1'b0);
    offer(CH_OR, 1'b0);
    offer("p", 1'b1);       // flush a trailing OR
    wait_all_results();

    // Random part.
    rand_start = sent_cnt;
    while (sent_cnt - rand_start < RANDOM_ITEMS) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      // Hold off the result side for a long stretch while requests keep
      // coming, so the block backs up and stalls its input.
      if (!hold_done && sent_cnt - rand_start > RANDOM_ITEMS / 3) begin
        long_hold = 1'b1;
        gap_max   = 0;
        hold_done = 1'b1;
      end
      if (!pause_done && sent_cnt - rand_start > 2 * RANDOM_ITEMS / 3) begin
        wait_all_results();
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 24);
      if (pick == 1) begin
        // Noise: raw bytes with a random end flag.
        repeat ($urandom_range(1, 4)) offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        if (pick == 0) build_deep_expr();
        else build_expr();
        send_expr();
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
